@@ design/plni_pkg.sv @@
// plni_pkg: widths, register codes, pipeline structs and width helpers
// for the periodic lattice neighbor index block. No dependencies.
`timescale 1ns / 1ps

package plni_pkg;

    localparam int IDX_W          = 20;
    localparam int CFG_W          = 6;
    localparam int CFG_IDX_W      = 2;
    localparam int NDIR           = 4;
    localparam int REG_MAX        = (1 << CFG_W) - 1;
    localparam int SIDE_RESET     = 8;
    localparam int DIMENSIONS_DEF = 4;
    localparam int MAX_SIDE_DEF   = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEN_T,
        REG_LEN_S1,
        REG_LEN_S2,
        REG_LEN_S3
    } t_reg_idx;

    // register that holds the side of each direction, slowest first
    localparam t_reg_idx DIR_REG [NDIR] = '{REG_LEN_T, REG_LEN_S1, REG_LEN_S2, REG_LEN_S3};

    typedef struct packed {
        logic valid;
        logic invalid;
    } t_pipe_ctl;

    typedef struct packed {
        logic [NDIR-1:0][IDX_W-1:0] fwd;
        logic [NDIR-1:0][IDX_W-1:0] bwd;
        logic                       invalid;
    } t_result;

    // largest side a register can take after clamping
    function automatic int side_max(input int max_side);
        return (max_side < REG_MAX) ? max_side : REG_MAX;
    endfunction

    function automatic int side_w(input int max_side);
        return $clog2(side_max(max_side) + 1);
    endfunction

    function automatic int coord_w(input int max_side);
        return $clog2(side_max(max_side));
    endfunction

endpackage

@@ design/plni_cfg.sv @@
// plni_cfg: side registers and the strides, wrap spans and volume derived
// from them, plus the settle counter after reset and writes. Uses plni_pkg.
`timescale 1ns / 1ps

module plni_cfg #(
    parameter int DIMENSIONS = plni_pkg::DIMENSIONS_DEF,
    parameter int MAX_SIDE   = plni_pkg::MAX_SIDE_DEF,
    parameter int SIDE_W     = 6,
    parameter int VOL_W      = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [plni_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [plni_pkg::CFG_W-1:0]     i_cfg_data,
    output logic [SIDE_W-1:0]              o_side   [DIMENSIONS],
    output logic [VOL_W-1:0]               o_stride [DIMENSIONS],
    output logic [VOL_W-1:0]               o_span   [DIMENSIONS],
    output logic [VOL_W-1:0]               o_vol,
    output logic                           o_busy
);
    import plni_pkg::*;

    localparam int SIDE_MAX = side_max(MAX_SIDE);
    localparam int SETTLE   = DIMENSIONS + 1;
    localparam int CNT_W    = $clog2(SETTLE + 1);

    logic [VOL_W-1:0] r_vol;
    logic [CNT_W-1:0] r_cnt;

    // zero acts as one, anything above the limit as the limit
    function automatic logic [SIDE_W-1:0] eff_side(input logic [CFG_W-1:0] v);
        logic [SIDE_W-1:0] res;
        if (v == '0) begin
            res = SIDE_W'(1);
        end else if (int'(v) > SIDE_MAX) begin
            res = SIDE_W'(SIDE_MAX);
        end else begin
            res = SIDE_W'(v);
        end
        return res;
    endfunction

    for (genvar j = 0; j < DIMENSIONS; j++) begin : g_dir
        logic [SIDE_W-1:0] r_len;
        logic [VOL_W-1:0]  r_span;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_len <= eff_side(CFG_W'(SIDE_RESET));
            end else if (i_cfg_we && i_cfg_idx == DIR_REG[j]) begin
                r_len <= eff_side(i_cfg_data);
            end
        end
        assign o_side[j] = r_len;

        // one multiply per cycle along the stride chain
        if (j == DIMENSIONS - 1) begin : g_fast
            assign o_stride[j] = VOL_W'(1);
        end else begin : g_slow
            logic [VOL_W-1:0] r_stride;
            always_ff @(posedge i_clk) begin
                r_stride <= VOL_W'(o_stride[j+1] * o_side[j+1]);
            end
            assign o_stride[j] = r_stride;
        end

        // span = (side - 1) * stride = next slower stride (volume for the slowest) minus own stride
        if (j == 0) begin : g_span_vol
            always_ff @(posedge i_clk) begin
                r_span <= r_vol - o_stride[j];
            end
        end else begin : g_span_str
            always_ff @(posedge i_clk) begin
                r_span <= o_stride[j-1] - o_stride[j];
            end
        end
        assign o_span[j] = r_span;
    end

    always_ff @(posedge i_clk) begin
        r_vol <= VOL_W'(o_stride[0] * o_side[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_W'(SETTLE);
        end else if (i_cfg_we) begin
            r_cnt <= CNT_W'(SETTLE);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    assign o_vol  = r_vol;
    assign o_busy = (r_cnt != '0);

endmodule

@@ design/plni_cell.sv @@
// plni_cell: one restoring-division step; tries one shifted stride on the
// remainder and sets one coordinate bit. Uses plni_pkg.
`timescale 1ns / 1ps

module plni_cell #(
    parameter int DIMENSIONS = plni_pkg::DIMENSIONS_DEF,
    parameter int VOL_W      = 24,
    parameter int CW         = 5,
    parameter int DIR        = 0,
    parameter int BIT        = 0
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_en,
    input  plni_pkg::t_pipe_ctl              i_ctl,
    input  logic [plni_pkg::IDX_W-1:0]       i_site,
    input  logic [plni_pkg::IDX_W-1:0]       i_rest,
    input  logic [DIMENSIONS-1:0][CW-1:0]    i_coord,
    input  logic [VOL_W-1:0]                 i_stride,
    output plni_pkg::t_pipe_ctl              o_ctl,
    output logic [plni_pkg::IDX_W-1:0]       o_site,
    output logic [plni_pkg::IDX_W-1:0]       o_rest,
    output logic [DIMENSIONS-1:0][CW-1:0]    o_coord
);
    import plni_pkg::*;

    localparam int AW = ((VOL_W + CW > IDX_W) ? VOL_W + CW : IDX_W) + 1;

    logic [AW-1:0]                w_rest;
    logic [AW-1:0]                w_sub;
    logic [AW-1:0]                w_diff;
    logic                         w_fit;
    logic [IDX_W-1:0]             n_rest;
    logic [DIMENSIONS-1:0][CW-1:0] n_coord;

    t_pipe_ctl                    r_ctl;
    logic [IDX_W-1:0]             r_site;
    logic [IDX_W-1:0]             r_rest;
    logic [DIMENSIONS-1:0][CW-1:0] r_coord;

    always_comb begin
        w_rest  = AW'(i_rest);
        w_sub   = AW'(i_stride) << BIT;
        w_fit   = (w_rest >= w_sub);
        w_diff  = w_rest - w_sub;
        n_rest  = w_fit ? w_diff[IDX_W-1:0] : i_rest;
        n_coord = i_coord;
        n_coord[DIR][BIT] = w_fit;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_site  <= i_site;
            r_rest  <= n_rest;
            r_coord <= n_coord;
        end
    end

    assign o_ctl   = r_ctl;
    assign o_site  = r_site;
    assign o_rest  = r_rest;
    assign o_coord = r_coord;

endmodule

@@ design/plni_nbr.sv @@
// plni_nbr: last cell of the row; steps each coordinate forward and back
// with wrap and forms the eight neighbor indices. Uses plni_pkg.
`timescale 1ns / 1ps

module plni_nbr #(
    parameter int DIMENSIONS = plni_pkg::DIMENSIONS_DEF,
    parameter int SIDE_W     = 6,
    parameter int VOL_W      = 24,
    parameter int CW         = 5
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  plni_pkg::t_pipe_ctl           i_ctl,
    input  logic [plni_pkg::IDX_W-1:0]    i_site,
    input  logic [DIMENSIONS-1:0][CW-1:0] i_coord,
    input  logic [SIDE_W-1:0]             i_side   [DIMENSIONS],
    input  logic [VOL_W-1:0]              i_stride [DIMENSIONS],
    input  logic [VOL_W-1:0]              i_span   [DIMENSIONS],
    output logic                          o_valid,
    output plni_pkg::t_result             o_res
);
    import plni_pkg::*;

    logic [DIMENSIONS-1:0] w_last;
    logic [DIMENSIONS-1:0] w_first;
    t_result               n_res;
    logic                  r_valid;
    t_result               r_res;

    // directions beyond the active ones stay zero
    always_comb begin
        n_res         = '0;
        n_res.invalid = i_ctl.invalid;
        for (int j = 0; j < DIMENSIONS; j++) begin
            w_last[j]  = (SIDE_W'(i_coord[j]) == i_side[j] - SIDE_W'(1));
            w_first[j] = (i_coord[j] == '0);
            if (!i_ctl.invalid) begin
                n_res.fwd[j] = w_last[j]  ? i_site - IDX_W'(i_span[j])
                                          : i_site + IDX_W'(i_stride[j]);
                n_res.bwd[j] = w_first[j] ? i_site + IDX_W'(i_span[j])
                                          : i_site - IDX_W'(i_stride[j]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

endmodule

@@ design/periodic_lattice_neighbor_index.sv @@
// periodic_lattice_neighbor_index: top level; input register, row of
// division cells, neighbor cell, output register and skid stage.
// Uses plni_pkg, plni_cfg, plni_cell and plni_nbr.
//
//   channel | handshake                   | payload
//   --------+-----------------------------+-----------------------------------
//   in      | i_in_valid / o_in_stall     | i_site_index
//   out     | o_out_valid / i_out_stall   | o_fwd_*, o_bwd_*, o_site_invalid
//   cfg     | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
// one item per cycle while o_in_stall is low; each cell of the row
// takes one coordinate bit of the site's coordinates.
// after reset and after every register write, o_in_stall is high while
// the stride chain settles.
// a stalled output parks one item in the skid stage; the row then freezes.
`timescale 1ns / 1ps

module periodic_lattice_neighbor_index #(
    parameter int DIMENSIONS = plni_pkg::DIMENSIONS_DEF,
    parameter int MAX_SIDE   = plni_pkg::MAX_SIDE_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [plni_pkg::IDX_W-1:0]     i_site_index,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [plni_pkg::IDX_W-1:0]     o_fwd_t,
    output logic [plni_pkg::IDX_W-1:0]     o_fwd_s1,
    output logic [plni_pkg::IDX_W-1:0]     o_fwd_s2,
    output logic [plni_pkg::IDX_W-1:0]     o_fwd_s3,
    output logic [plni_pkg::IDX_W-1:0]     o_bwd_t,
    output logic [plni_pkg::IDX_W-1:0]     o_bwd_s1,
    output logic [plni_pkg::IDX_W-1:0]     o_bwd_s2,
    output logic [plni_pkg::IDX_W-1:0]     o_bwd_s3,
    output logic                           o_site_invalid,
    input  logic                           i_cfg_we,
    input  logic [plni_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [plni_pkg::CFG_W-1:0]     i_cfg_data
);
    import plni_pkg::*;

    localparam int SIDE_W = side_w(MAX_SIDE);
    localparam int CW     = coord_w(MAX_SIDE);
    localparam int VOL_W  = DIMENSIONS * SIDE_W;
    localparam int CMP_W  = (VOL_W > IDX_W) ? VOL_W : IDX_W;
    localparam int NCELL  = DIMENSIONS * CW;

    logic [SIDE_W-1:0] w_side   [DIMENSIONS];
    logic [VOL_W-1:0]  w_stride [DIMENSIONS];
    logic [VOL_W-1:0]  w_span   [DIMENSIONS];
    logic [VOL_W-1:0]  w_vol;
    logic              w_cfg_busy;

    logic              w_en;
    logic              w_in_acc;
    logic              w_site_bad;
    logic              w_pass;
    logic              w_take;

    t_pipe_ctl         r_in_ctl;
    logic [IDX_W-1:0]  r_site;

    t_pipe_ctl                     s_ctl   [NCELL+1];
    logic [IDX_W-1:0]              s_site  [NCELL+1];
    logic [IDX_W-1:0]              s_rest  [NCELL+1];
    logic [DIMENSIONS-1:0][CW-1:0] s_coord [NCELL+1];

    logic              w_nbr_valid;
    t_result           w_nbr_res;

    logic              r_out_valid;
    t_result           r_out;
    logic              r_skid_full;
    t_result           r_skid;

    plni_cfg #(
        .DIMENSIONS (DIMENSIONS),
        .MAX_SIDE   (MAX_SIDE),
        .SIDE_W     (SIDE_W),
        .VOL_W      (VOL_W)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_side     (w_side),
        .o_stride   (w_stride),
        .o_span     (w_span),
        .o_vol      (w_vol),
        .o_busy     (w_cfg_busy)
    );

    // the whole row moves unless an item sits in the skid stage
    assign w_en       = !r_skid_full;
    assign o_in_stall = r_skid_full || w_cfg_busy;
    assign w_in_acc   = i_in_valid && !o_in_stall;
    assign w_site_bad = (CMP_W'(i_site_index) >= CMP_W'(w_vol));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (w_en) begin
            r_in_ctl.valid   <= w_in_acc;
            r_in_ctl.invalid <= w_site_bad;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_site <= i_site_index;
        end
    end

    assign s_ctl[0]   = r_in_ctl;
    assign s_site[0]  = r_site;
    assign s_rest[0]  = r_site;
    assign s_coord[0] = '0;

    // slowest direction first, high coordinate bit first
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        plni_cell #(
            .DIMENSIONS (DIMENSIONS),
            .VOL_W      (VOL_W),
            .CW         (CW),
            .DIR        (k / CW),
            .BIT        (CW - 1 - (k % CW))
        ) u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_ctl    (s_ctl[k]),
            .i_site   (s_site[k]),
            .i_rest   (s_rest[k]),
            .i_coord  (s_coord[k]),
            .i_stride (w_stride[k / CW]),
            .o_ctl    (s_ctl[k+1]),
            .o_site   (s_site[k+1]),
            .o_rest   (s_rest[k+1]),
            .o_coord  (s_coord[k+1])
        );
    end

    plni_nbr #(
        .DIMENSIONS (DIMENSIONS),
        .SIDE_W     (SIDE_W),
        .VOL_W      (VOL_W),
        .CW         (CW)
    ) u_nbr (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (w_en),
        .i_ctl    (s_ctl[NCELL]),
        .i_site   (s_site[NCELL]),
        .i_coord  (s_coord[NCELL]),
        .i_side   (w_side),
        .i_stride (w_stride),
        .i_span   (w_span),
        .o_valid  (w_nbr_valid),
        .o_res    (w_nbr_res)
    );

    assign w_pass = w_en && w_nbr_valid;
    assign w_take = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skid_full <= 1'b0;
        end else if (r_skid_full) begin
            if (w_take) begin
                r_skid_full <= 1'b0;
            end
        end else if (w_pass) begin
            if (r_out_valid && !w_take) begin
                r_skid_full <= 1'b1;
            end else begin
                r_out_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_full) begin
            if (w_take) begin
                r_out <= r_skid;
            end
        end else if (w_pass) begin
            if (r_out_valid && !w_take) begin
                r_skid <= w_nbr_res;
            end else begin
                r_out <= w_nbr_res;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_fwd_t        = r_out.fwd[0];
    assign o_fwd_s1       = r_out.fwd[1];
    assign o_fwd_s2       = r_out.fwd[2];
    assign o_fwd_s3       = r_out.fwd[3];
    assign o_bwd_t        = r_out.bwd[0];
    assign o_bwd_s1       = r_out.bwd[1];
    assign o_bwd_s2       = r_out.bwd[2];
    assign o_bwd_s3       = r_out.bwd[3];
    assign o_site_invalid = r_out.invalid;

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_full |-> r_out_valid)
        else $error("skid stage full while output register empty");

    a_skid_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_full) |-> $past(r_out_valid && i_out_stall))
        else $error("skid stage filled without a stalled output");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_site_invalid) |->
            (o_fwd_t == '0 && o_bwd_t == '0 && o_fwd_s1 == '0 && o_bwd_s1 == '0 &&
             o_fwd_s2 == '0 && o_bwd_s2 == '0 && o_fwd_s3 == '0 && o_bwd_s3 == '0))
        else $error("invalid site item carries nonzero neighbors");

endmodule

@@ test/periodic_lattice_neighbor_index_tb.sv @@
// periodic_lattice_neighbor_index_tb: self-checking testbench with a queue-fed driver, a
// clocked monitor and a built-in neighbor predictor; sweeps side settings and idle patterns.
// Depends on plni_pkg and periodic_lattice_neighbor_index.
`timescale 1ns / 1ps

module periodic_lattice_neighbor_index_tb;
    import plni_pkg::*;

    localparam int LATENCY     = DIMENSIONS_DEF * $clog2(MAX_SIDE_DEF) + 3;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASES      = 13;
    localparam int RANDOM_PER_PHASE = 110;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic [IDX_W-1:0]      i_site_index   = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic [IDX_W-1:0]      o_fwd_t, o_fwd_s1, o_fwd_s2, o_fwd_s3;
    logic [IDX_W-1:0]      o_bwd_t, o_bwd_s1, o_bwd_s2, o_bwd_s3;
    logic                  o_site_invalid;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = REG_LEN_T;
    logic [CFG_W-1:0]      i_cfg_data     = '0;

    // local copy of the side registers, slowest direction first
    logic [CFG_W-1:0]      side_reg [NDIR] = '{default: CFG_W'(SIDE_RESET)};

    logic [IDX_W-1:0]      site_q [$];
    t_result               nbr_q [$];
    int                    send_gap_pct   = 0;
    int                    recv_stall_pct = 0;
    int                    fail_count     = 0;
    int                    cycle_count    = 0;
    string                 dir_name [NDIR] = '{"t", "s1", "s2", "s3"};

    periodic_lattice_neighbor_index uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_site_index   (i_site_index),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_fwd_t        (o_fwd_t),
        .o_fwd_s1       (o_fwd_s1),
        .o_fwd_s2       (o_fwd_s2),
        .o_fwd_s3       (o_fwd_s3),
        .o_bwd_t        (o_bwd_t),
        .o_bwd_s1       (o_bwd_s1),
        .o_bwd_s2       (o_bwd_s2),
        .o_bwd_s3       (o_bwd_s3),
        .o_site_invalid (o_site_invalid),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // zero acts as one, anything above the limit as the limit
    function automatic longint unsigned side_of(input int dir);
        if (side_reg[dir] == 0) return 1;
        if (side_reg[dir] > MAX_SIDE_DEF) return MAX_SIDE_DEF;
        return side_reg[dir];
    endfunction

    function automatic longint unsigned stride_of(input int dir);
        longint unsigned s;
        s = 1;
        for (int k = dir + 1; k < NDIR; k++) s *= side_of(k);
        return s;
    endfunction

    function automatic t_result neighbors_of(input logic [IDX_W-1:0] site);
        t_result         r;
        longint unsigned rest, coord, stride, side, base, up, dn;
        r = '0;
        if (site >= stride_of(0) * side_of(0)) begin
            r.invalid = 1'b1;
            return r;
        end
        rest = site;
        for (int j = 0; j < NDIR; j++) begin
            stride = stride_of(j);
            side   = side_of(j);
            coord  = rest / stride;
            rest   = rest % stride;
            base   = site - coord * stride;
            up     = (coord + 1 >= side) ? 0 : coord + 1;
            dn     = (coord == 0) ? side - 1 : coord - 1;
            r.fwd[j] = IDX_W'(base + up * stride);
            r.bwd[j] = IDX_W'(base + dn * stride);
        end
        return r;
    endfunction

    task automatic load_sides(input logic [CFG_W-1:0] lt, ls1, ls2, ls3);
        logic [CFG_W-1:0] vals [NDIR];
        vals = '{lt, ls1, ls2, ls3};
        for (int j = 0; j < NDIR; j++) begin
            @(posedge i_clk);
            i_cfg_we   <= 1'b1;
            i_cfg_idx  <= DIR_REG[j];
            i_cfg_data <= vals[j];
            side_reg[j] = vals[j];
        end
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // lattice corners, volume edge, largest index and single-coordinate wraps
    task automatic add_corner_sites();
        longint unsigned vol, top;
        vol = stride_of(0) * side_of(0);
        site_q.push_back('0);
        site_q.push_back(IDX_W'(vol - 1));
        if (vol < (1 << IDX_W)) site_q.push_back(IDX_W'(vol));
        site_q.push_back({IDX_W{1'b1}});
        for (int j = 0; j < NDIR; j++) begin
            top = (side_of(j) - 1) * stride_of(j);
            site_q.push_back(IDX_W'(top));
            site_q.push_back(IDX_W'(vol - 1 - top));
        end
    endtask

    task automatic add_sites(input int count);
        longint unsigned vol, site;
        int              pick, sel;
        vol = stride_of(0) * side_of(0);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                // any index, mostly out of range on small lattices
                site = $urandom_range(0, (1 << IDX_W) - 1);
            end else if (pick < 42) begin
                // each coordinate at an edge or anywhere
                site = 0;
                for (int j = 0; j < NDIR; j++) begin
                    sel = $urandom_range(0, 2);
                    if (sel == 1)
                        site += (side_of(j) - 1) * stride_of(j);
                    else if (sel == 2)
                        site += $urandom_range(0, side_of(j) - 1) * stride_of(j);
                end
            end else begin
                site = $urandom_range(0, vol - 1);
            end
            site_q.push_back(site[IDX_W-1:0]);
        end
    endtask

    task automatic wait_drained();
        while (site_q.size() != 0 || i_in_valid || nbr_q.size() != 0) @(negedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) nbr_q.push_back(neighbors_of(i_site_index));
            if (!i_in_valid || !o_in_stall) begin
                if (site_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct) begin
                    i_in_valid   <= 1'b1;
                    i_site_index <= site_q.pop_front();
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_result got, want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (o_out_valid && !i_out_stall) begin
                got.fwd     = {o_fwd_s3, o_fwd_s2, o_fwd_s1, o_fwd_t};
                got.bwd     = {o_bwd_s3, o_bwd_s2, o_bwd_s1, o_bwd_t};
                got.invalid = o_site_invalid;
                if (nbr_q.size() == 0) begin
                    $error("item on output with none expected");
                    fail_count++;
                end else begin
                    want = nbr_q.pop_front();
                    if (got != want) fail_count++;
                    for (int j = 0; j < NDIR; j++) begin
                        if (got.fwd[j] !== want.fwd[j])
                            $error("fwd_%s: expected %0d, got %0d",
                                   dir_name[j], want.fwd[j], got.fwd[j]);
                        if (got.bwd[j] !== want.bwd[j])
                            $error("bwd_%s: expected %0d, got %0d",
                                   dir_name[j], want.bwd[j], got.bwd[j]);
                    end
                    if (got.invalid !== want.invalid)
                        $error("site_invalid: expected %0d, got %0d", want.invalid, got.invalid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < PHASES; p++) begin
            if (p > 0) begin
                wait_drained();
                case (p)
                    1:       load_sides(32, 32, 32, 32);
                    2:       load_sides(1, 1, 1, 1);
                    3:       load_sides(0, 0, 0, 0);
                    4:       load_sides(63, 63, 63, 63);
                    5:       load_sides(33, 5, 1, 7);
                    6:       load_sides(3, 0, 32, 2);
                    7:       load_sides(17, 1, 63, 9);
                    default: load_sides($urandom_range(0, 63), $urandom_range(0, 63),
                                        $urandom_range(0, 63), $urandom_range(0, 63));
                endcase
            end
            case (p % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 56; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 56; end
                default: begin send_gap_pct = 8; recv_stall_pct = 8; end
            endcase
            add_corner_sites();
            add_sites(RANDOM_PER_PHASE);
        end
        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
